/* rtl/mbr_pkg.sv */
// ----------------------------------------------------------------------------
// mbr_pkg: shared types and constants
// Item, run descriptor and register codes for the bitmap to RGB565 stream.
// ----------------------------------------------------------------------------
package mbr_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_OP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_OP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_OP = 2'd2;

  localparam logic [7:0] COLUMN_OP_RESET = 8'd42;
  localparam logic [7:0] ROW_OP_RESET    = 8'd43;
  localparam logic [7:0] MEMORY_OP_RESET = 8'd44;

  // input command codes
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_BITMAP = 1'b1;

  // byte positions inside the start sequence
  localparam logic [3:0] IDX_COLUMN_OP = 4'd0;
  localparam logic [3:0] IDX_X0_HI     = 4'd1;
  localparam logic [3:0] IDX_X0_LO     = 4'd2;
  localparam logic [3:0] IDX_X1_HI     = 4'd3;
  localparam logic [3:0] IDX_X1_LO     = 4'd4;
  localparam logic [3:0] IDX_ROW_OP    = 4'd5;
  localparam logic [3:0] IDX_Y0_HI     = 4'd6;
  localparam logic [3:0] IDX_Y0_LO     = 4'd7;
  localparam logic [3:0] IDX_Y1_HI     = 4'd8;
  localparam logic [3:0] IDX_Y1_LO     = 4'd9;
  localparam logic [3:0] IDX_MEMORY_OP = 4'd10;

  localparam logic [7:0] PIXELS_PER_BYTE = 8'd8;

  typedef struct packed {
    logic        cmd;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [7:0]  image_width;
    logic [7:0]  image_height;
    logic [15:0] fore_color;
    logic [15:0] back_color;
    logic [7:0]  bitmap_byte;
  } item_t;

  // everything the byte sequencer needs to play out one run
  typedef struct packed {
    logic        is_start;
    logic [7:0]  column_op;
    logic [7:0]  row_op;
    logic [7:0]  memory_op;
    logic [15:0] x0;
    logic [15:0] x1;
    logic [15:0] y0;
    logic [15:0] y1;
    logic [7:0]  bits;
    logic [15:0] fore;
    logic [15:0] back;
    logic [3:0]  last_idx;
    logic        done;
  } run_t;

endpackage

/* rtl/mbr_item_if.sv */
// ----------------------------------------------------------------------------
// mbr_item_if: input word channel
// Valid/ready channel carrying start and bitmap words.
// ----------------------------------------------------------------------------
interface mbr_item_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] center_x;
  logic [15:0] center_y;
  logic [7:0]  image_width;
  logic [7:0]  image_height;
  logic [15:0] fore_color;
  logic [15:0] back_color;
  logic [7:0]  bitmap_byte;

  modport source (
    output valid, cmd, center_x, center_y, image_width, image_height,
           fore_color, back_color, bitmap_byte,
    input  ready
  );
  modport sink (
    input  valid, cmd, center_x, center_y, image_width, image_height,
           fore_color, back_color, bitmap_byte,
    output ready
  );
endinterface

// ----------------------------------------------------------------------------
// mbr_link_if: output word channel
// Valid/ready channel carrying display link bytes with their flags.
// ----------------------------------------------------------------------------
interface mbr_link_if;
  logic       valid;
  logic       ready;
  logic [7:0] link_byte;
  logic       is_command;
  logic       last_of_run;
  logic       image_done;

  modport source (
    output valid, link_byte, is_command, last_of_run, image_done,
    input  ready
  );
  modport sink (
    input  valid, link_byte, is_command, last_of_run, image_done,
    output ready
  );
endinterface

/* rtl/mbr_front.sv */
// ----------------------------------------------------------------------------
// mbr_front: input register, image state and run descriptor
// Holds one word, works out the window or the pixel run, tracks position.
// ----------------------------------------------------------------------------
module mbr_front
  import mbr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  mbr_item_if.sink             px_in,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output logic                 desc_valid,
  output run_t                 desc,
  input  logic                 desc_ready
);

  logic       column_op, row_op, memory_op;
  logic [7:0] column_op_reg, row_op_reg, memory_op_reg;
  logic       item_valid;
  item_t      item;

  logic        drawing_active;
  logic [7:0]  column_position, row_position;
  logic [7:0]  held_width, held_height;
  logic [15:0] held_fore, held_back;

  logic        has_result, advance;
  logic [7:0]  remaining, row_next;
  logic [3:0]  count;
  logic        row_end, done;
  logic [15:0] half_x, half_y;

  assign column_op = cfg_we && (cfg_index == CFG_COLUMN_OP);
  assign row_op    = cfg_we && (cfg_index == CFG_ROW_OP);
  assign memory_op = cfg_we && (cfg_index == CFG_MEMORY_OP);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_op_reg <= COLUMN_OP_RESET;
      row_op_reg    <= ROW_OP_RESET;
      memory_op_reg <= MEMORY_OP_RESET;
    end else begin
      if (column_op) column_op_reg <= cfg_data;
      if (row_op)    row_op_reg    <= cfg_data;
      if (memory_op) memory_op_reg <= cfg_data;
    end
  end

  assign has_result   = (item.cmd == CMD_START) || drawing_active;
  assign desc_valid   = item_valid && has_result;
  assign advance      = item_valid && (!has_result || desc_ready);
  assign px_in.ready  = !item_valid || advance;

  // pixel run arithmetic
  assign remaining = held_width - column_position;
  assign row_end   = (remaining <= PIXELS_PER_BYTE);
  assign count     = row_end ? remaining[3:0] : PIXELS_PER_BYTE[3:0];
  assign row_next  = row_position + 8'd1;
  assign done      = row_end && (row_next >= held_height);

  assign half_x = {9'd0, item.image_width[7:1]};
  assign half_y = {9'd0, item.image_height[7:1]};

  always_comb begin
    desc.is_start  = (item.cmd == CMD_START);
    desc.column_op = column_op_reg;
    desc.row_op    = row_op_reg;
    desc.memory_op = memory_op_reg;
    desc.x0        = item.center_x - half_x;
    desc.x1        = item.center_x + half_x - {15'd0, ~item.image_width[0]};
    desc.y0        = item.center_y - half_y;
    desc.y1        = item.center_y + half_y - {15'd0, ~item.image_height[0]};
    desc.bits      = item.bitmap_byte;
    desc.fore      = held_fore;
    desc.back      = held_back;
    desc.last_idx  = desc.is_start ? IDX_MEMORY_OP : {count[2:0], 1'b0} - 4'd1;
    desc.done      = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (px_in.valid && px_in.ready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
    if (px_in.valid && px_in.ready) begin
      item.cmd          <= px_in.cmd;
      item.center_x     <= px_in.center_x;
      item.center_y     <= px_in.center_y;
      item.image_width  <= px_in.image_width;
      item.image_height <= px_in.image_height;
      item.fore_color   <= px_in.fore_color;
      item.back_color   <= px_in.back_color;
      item.bitmap_byte  <= px_in.bitmap_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drawing_active  <= 1'b0;
      column_position <= '0;
      row_position    <= '0;
      held_width      <= '0;
      held_height     <= '0;
      held_fore       <= '0;
      held_back       <= '0;
    end else if (advance) begin
      if (item.cmd == CMD_START) begin
        held_width      <= item.image_width;
        held_height     <= item.image_height;
        held_fore       <= item.fore_color;
        held_back       <= item.back_color;
        column_position <= '0;
        row_position    <= '0;
        drawing_active  <= (item.image_width != 8'd0) && (item.image_height != 8'd0);
      end else if (drawing_active) begin
        if (row_end) begin
          column_position <= '0;
          row_position    <= row_next;
          if (done) drawing_active <= 1'b0;
        end else begin
          column_position <= column_position + PIXELS_PER_BYTE;
        end
      end
    end
  end

  a_active_size: assert property (@(posedge clk) disable iff (rst)
    drawing_active |-> (held_width != 8'd0) && (held_height != 8'd0))
    else $error("image active with empty size");
  a_column_inside: assert property (@(posedge clk) disable iff (rst)
    drawing_active |-> column_position < held_width)
    else $error("column position past image width");
  a_row_inside: assert property (@(posedge clk) disable iff (rst)
    drawing_active |-> row_position < held_height)
    else $error("row position past image height");

endmodule

/* rtl/mbr_serial.sv */
// ----------------------------------------------------------------------------
// mbr_serial: run register and byte sequencer
// Plays one run out a byte per cycle into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module mbr_serial
  import mbr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       desc_valid,
  input  run_t       desc,
  output logic       desc_ready,
  mbr_link_if.source link_out
);

  logic       run_valid;
  run_t       run;
  logic [3:0] idx;
  logic       load, last, out_valid;
  logic [7:0] next_byte;
  logic       next_cmd;
  logic       pixel_bit;
  logic [15:0] color;

  assign load       = run_valid && (!out_valid || link_out.ready);
  assign last       = (idx == run.last_idx);
  assign desc_ready = !run_valid || (load && last);

  assign pixel_bit = run.bits[3'd7 - idx[3:1]];
  assign color     = pixel_bit ? run.fore : run.back;

  always_comb begin
    next_cmd  = 1'b0;
    next_byte = idx[0] ? color[7:0] : color[15:8];
    if (run.is_start) begin
      unique case (idx)
        IDX_COLUMN_OP: begin next_byte = run.column_op; next_cmd = 1'b1; end
        IDX_X0_HI:     next_byte = run.x0[15:8];
        IDX_X0_LO:     next_byte = run.x0[7:0];
        IDX_X1_HI:     next_byte = run.x1[15:8];
        IDX_X1_LO:     next_byte = run.x1[7:0];
        IDX_ROW_OP:    begin next_byte = run.row_op; next_cmd = 1'b1; end
        IDX_Y0_HI:     next_byte = run.y0[15:8];
        IDX_Y0_LO:     next_byte = run.y0[7:0];
        IDX_Y1_HI:     next_byte = run.y1[15:8];
        IDX_Y1_LO:     next_byte = run.y1[7:0];
        IDX_MEMORY_OP: begin next_byte = run.memory_op; next_cmd = 1'b1; end
        default:       next_byte = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (link_out.ready) out_valid <= 1'b0;
      if (desc_ready) run_valid <= desc_valid;
    end
    if (desc_ready && desc_valid) begin
      run <= desc;
      idx <= '0;
    end else if (load) begin
      idx <= idx + 4'd1;
    end
    if (load) begin
      link_out.link_byte   <= next_byte;
      link_out.is_command  <= next_cmd;
      link_out.last_of_run <= last;
      link_out.image_done  <= last && !run.is_start && run.done;
    end
  end

  assign link_out.valid = out_valid;

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    run_valid |-> idx <= run.last_idx)
    else $error("byte index past end of run");
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && link_out.image_done |-> link_out.last_of_run)
    else $error("image done off the last byte of a run");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !link_out.ready |=> out_valid && $stable(link_out.link_byte))
    else $error("output word dropped under stall");

endmodule

/* rtl/mono_bitmap_to_rgb565_lcd_stream.sv */
// ----------------------------------------------------------------------------
// mono_bitmap_to_rgb565_lcd_stream: one-bit bitmap to RGB565 link stream
// Turns start words into window commands and bitmap words into pixel bytes.
// ----------------------------------------------------------------------------
//
//  channel    dir  handshake          contents
//  ---------  ---  -----------------  --------------------------------------
//  px_in      in   valid/ready        cmd, center, size, colors, bitmap byte
//  link_out   out  valid/ready        link byte, command, last, image done
//  cfg        in   cfg_we, no stall   index 0..2 opcodes, 8-bit data
//
//  A start word gives 11 bytes, a bitmap word 2 bytes per valid pixel
//  (2..16); the byte sequencer sends one byte per cycle while the output
//  is not stalled and is the limit. A bitmap word with no image active
//  gives nothing. The first byte passes through the word register, the run
//  register and the output register. Reset (rst, synchronous) drops all
//  words in flight and restores the default opcodes. The next word is taken
//  while the current run plays out; a stalled output holds its byte.
//
module mono_bitmap_to_rgb565_lcd_stream
  import mbr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  mbr_item_if.sink             px_in,
  mbr_link_if.source           link_out,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  // descriptor hand-off between the front end and the sequencer
  logic desc_valid;
  logic desc_ready;
  run_t desc;

  // front: word register, window math, image position tracking
  mbr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .px_in      (px_in),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .desc_valid (desc_valid),
    .desc       (desc),
    .desc_ready (desc_ready)
  );

  // sequencer: one byte per cycle into the output register, unless the output stalls
  mbr_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (desc_valid),
    .desc       (desc),
    .desc_ready (desc_ready),
    .link_out   (link_out)
  );

endmodule
